// ===== rtl/psu_pkg.sv =====
// psu_pkg: shared types and constants of the png scanline unfilter
// register indexes, filter codes, field widths and the item struct between
// the position control and the reconstruction stage; no dependencies
package psu_pkg;

	localparam int DEF_MAX_WIDTH      = 4096;
	localparam int DEF_MAX_COMPONENTS = 4;

	localparam int ROW_WIDTH_W = 13;
	localparam int BPP_W       = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;
	localparam int COMP_W      = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH       = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'd1;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	typedef struct packed {
		logic              is_sample;
		logic              first_row;
		logic [2:0]        filter;
		logic [COMP_W-1:0] comp;
		logic              last;
		logic [7:0]        data;
	} item_t;

endpackage

// ===== rtl/psu_ctrl.sv =====
// psu_ctrl: configuration registers and scanline position counters
// classifies each accepted byte and forms its line store address; uses psu_pkg
module psu_ctrl #(
	parameter int MAX_WIDTH      = psu_pkg::DEF_MAX_WIDTH,
	parameter int MAX_COMPONENTS = psu_pkg::DEF_MAX_COMPONENTS,
	parameter int AW             = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           accept,
	input  logic [7:0]                     data_byte,
	input  logic                           start_of_image,
	output psu_pkg::item_t                 item,
	output logic [AW-1:0]                  addr
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [psu_pkg::ROW_WIDTH_W-1:0] row_width_q;
	logic [psu_pkg::BPP_W-1:0]       bpp_q;
	logic [CW-1:0]                   col_q;
	logic [psu_pkg::COMP_W-1:0]      comp_q;
	logic [2:0]                      filter_q;
	logic                            expect_q;
	logic                            first_q;

	logic [CW-1:0]              last_col;
	logic [psu_pkg::COMP_W-1:0] last_comp;
	logic [CW-1:0]              col;
	logic [psu_pkg::COMP_W-1:0] comp;
	logic                       expect_eff;
	logic                       first_eff;
	logic                       col_end;
	logic                       comp_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= psu_pkg::ROW_WIDTH_W'(1);
			bpp_q       <= psu_pkg::BPP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				psu_pkg::REG_ROW_WIDTH:       row_width_q <= cfg_data;
				psu_pkg::REG_BYTES_PER_PIXEL: bpp_q <= cfg_data[psu_pkg::BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the limits to the supported range, kept as last index
	always_comb begin
		if (row_width_q == '0)
			last_col = '0;
		else if (32'(row_width_q) > MAX_WIDTH)
			last_col = CW'(MAX_WIDTH - 1);
		else
			last_col = CW'(32'(row_width_q) - 1);

		if (bpp_q == '0)
			last_comp = '0;
		else if (32'(bpp_q) > MAX_COMPONENTS)
			last_comp = psu_pkg::COMP_W'(MAX_COMPONENTS - 1);
		else
			last_comp = psu_pkg::COMP_W'(32'(bpp_q) - 1);
	end

	always_comb begin
		expect_eff = expect_q | start_of_image;
		first_eff  = first_q | start_of_image;
		col        = (col_q > last_col) ? last_col : col_q;
		comp       = (comp_q > last_comp) ? last_comp : comp_q;
		col_end    = (col >= last_col);
		comp_end   = (comp >= last_comp);
		addr       = AW'(32'(col) * MAX_COMPONENTS + 32'(comp));

		item.is_sample = !expect_eff;
		item.first_row = first_eff;
		item.filter    = filter_q;
		item.comp      = comp;
		item.last      = col_end & comp_end;
		item.data      = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			comp_q   <= '0;
			filter_q <= psu_pkg::FILT_NONE;
			expect_q <= 1'b1;
			first_q  <= 1'b1;
		end else if (accept) begin
			if (expect_eff) begin
				// unknown filter codes fall back to none
				filter_q <= (data_byte > 8'd4) ? psu_pkg::FILT_NONE : data_byte[2:0];
				col_q    <= '0;
				comp_q   <= '0;
				expect_q <= 1'b0;
				first_q  <= first_eff;
			end else if (comp_end) begin
				comp_q <= '0;
				if (col_end) begin
					col_q    <= '0;
					expect_q <= 1'b1;
					first_q  <= 1'b0;
				end else begin
					col_q <= CW'(32'(col) + 1);
				end
			end else begin
				comp_q <= psu_pkg::COMP_W'(comp + 1'b1);
				col_q  <= col;
			end
		end
	end

endmodule

// ===== rtl/psu_line_store.sv =====
// psu_line_store: previous-row sample memory, one write and one read port
// read data registered; no package dependency
module psu_line_store #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// held while the reading item waits in the next stage
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/psu_recon.sv =====
// psu_recon: reconstruction stage, neighbour registers and output register
// applies sub/up/average/paeth and writes the row back; uses psu_pkg
module psu_recon #(
	parameter int AW = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  psu_pkg::item_t            item,
	input  logic [AW-1:0]             addr,
	input  logic [7:0]                up_data,
	output logic                      stage_free,
	output logic                      wr_en,
	output logic [AW-1:0]             wr_addr,
	output logic [7:0]                wr_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_sample,
	output logic [psu_pkg::COMP_W-1:0] out_comp,
	output logic                      out_last
);

	logic           valid_s1;
	psu_pkg::item_t item_s1;
	logic [AW-1:0]  addr_s1;

	logic [7:0] left_q [4];
	logic [7:0] upleft_q [4];

	logic                       out_valid_q;
	logic [7:0]                 sample_q;
	logic [psu_pkg::COMP_W-1:0] comp_q;
	logic                       last_q;

	logic       adv;
	logic [7:0] a, b, c, pred, value;
	logic [8:0] sum_ab;
	logic [9:0] two_c;
	logic [8:0] pa, pb;
	logic [9:0] pc;

	// filter bytes move on without taking the output register
	assign adv        = valid_s1 & (!item_s1.is_sample | !out_valid_q | out_ready);
	assign stage_free = !valid_s1 | adv;

	always_comb begin
		a      = left_q[item_s1.comp];
		c      = upleft_q[item_s1.comp];
		b      = item_s1.first_row ? 8'd0 : up_data;
		sum_ab = {1'b0, a} + {1'b0, b};
		two_c  = {1'b0, c, 1'b0};
		pa     = (b >= c) ? 9'(b - c) : 9'(c - b);
		pb     = (a >= c) ? 9'(a - c) : 9'(c - a);
		pc     = ({1'b0, sum_ab} >= two_c) ? ({1'b0, sum_ab} - two_c)
		                                    : (two_c - {1'b0, sum_ab});

		unique case (item_s1.filter)
			psu_pkg::FILT_SUB: pred = a;
			psu_pkg::FILT_UP:  pred = b;
			psu_pkg::FILT_AVG: pred = sum_ab[8:1];
			psu_pkg::FILT_PAETH: begin
				priority if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc)
					pred = a;
				else if ({1'b0, pb} <= pc)
					pred = b;
				else
					pred = c;
			end
			default: pred = 8'd0;
		endcase

		value = item_s1.data + pred;
	end

	// consecutive samples never share an address, so no forwarding path
	assign wr_en   = adv & item_s1.is_sample;
	assign wr_addr = addr_s1;
	assign wr_data = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			addr_s1 <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else if (adv) begin
			if (!item_s1.is_sample) begin
				for (int i = 0; i < 4; i++) begin
					left_q[i]   <= 8'd0;
					upleft_q[i] <= 8'd0;
				end
			end else begin
				left_q[item_s1.comp]   <= value;
				upleft_q[item_s1.comp] <= b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && item_s1.is_sample)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.is_sample) begin
			sample_q <= value;
			comp_q   <= item_s1.comp;
			last_q   <= item_s1.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = sample_q;
	assign out_comp   = comp_q;
	assign out_last   = last_q;

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
// png_scanline_unfilter: undoes the png row filters for 8-bit samples.
// Takes the inflated stream a byte at a time: each row is a filter byte
// followed by row_width * bytes_per_pixel samples, and every sample gives one
// reconstructed item. Sustained rate is one byte per cycle while the output
// side is ready. An accepted sample is registered in the predictor stage, and
// the same edge registers the line store read of its up neighbour; the
// predictor result is then captured in the output register, from which the
// item leaves. A filter byte gives no item and leaves the predictor stage
// without waiting for the output register. While the output register is full
// and not taken, a sample waiting in the predictor stage holds the input off.
// The line store holds MAX_WIDTH * MAX_COMPONENTS bytes with one read and one
// write port, is not cleared after reset and its data is used only from the
// second row of an image on, so the block is ready at once.
// Depends on psu_pkg, psu_ctrl, psu_line_store and psu_recon.
module png_scanline_unfilter #(
	parameter int MAX_WIDTH      = psu_pkg::DEF_MAX_WIDTH,
	parameter int MAX_COMPONENTS = psu_pkg::DEF_MAX_COMPONENTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]                      s_axis_tuser,  // [0] start_of_image
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // [7:0] sample
	output logic [psu_pkg::COMP_W-1:0]      m_axis_tuser,  // [1:0] component
	output logic                            m_axis_tlast   // row_last
);

	localparam int DEPTH = MAX_WIDTH * MAX_COMPONENTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic           accept;
	logic           stage_free;
	psu_pkg::item_t item;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     up_data;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;

	assign s_axis_tready = stage_free;
	assign accept        = s_axis_tvalid & stage_free;

	psu_ctrl #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.AW             (AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.data_byte      (s_axis_tdata),
		.start_of_image (s_axis_tuser[0]),
		.item           (item),
		.addr           (rd_addr)
	);

	psu_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept & item.is_sample),
		.raddr (rd_addr),
		.rdata (up_data)
	);

	psu_recon #(
		.AW (AW)
	) u_recon (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.addr       (rd_addr),
		.up_data    (up_data),
		.stage_free (stage_free),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (m_axis_tdata),
		.out_comp   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for png_scanline_unfilter: drives filtered scanlines and checks
// every reconstructed sample against a predictor of the png row filters
// depends on psu_pkg and the png_scanline_unfilter rtl
module testbench;

	localparam int STORE_DEPTH   = psu_pkg::DEF_MAX_WIDTH * psu_pkg::DEF_MAX_COMPONENTS;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int WIDE_ITEMS    = 72;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int DIRECTED_LEN  = 30;

	typedef struct packed {
		logic [7:0]                 sample;
		logic [psu_pkg::COMP_W-1:0] comp;
		logic                       last;
	} px_t;

	typedef enum logic {STEP_BYTE, STEP_CONFIG} step_kind_e;

	typedef struct packed {
		step_kind_e kind;
		logic [12:0] val;     // data byte, or row width for a config step
		logic [2:0]  bpp;
		logic        sof;
		logic        typed;
		logic [7:0]  sample;
		logic [1:0]  comp;
		logic        last;
	} step_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_e;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index = psu_pkg::REG_ROW_WIDTH;
	logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [7:0]                      s_axis_tdata = '0;
	logic [0:0]                      s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [7:0]                      m_axis_tdata;
	logic [psu_pkg::COMP_W-1:0]      m_axis_tuser;
	logic                            m_axis_tlast;

	// predictor state
	logic [12:0] cfg_width = 13'd1;
	logic [2:0]  cfg_bpp = 3'd1;
	logic [7:0]  prev_row [0:STORE_DEPTH-1];
	logic [7:0]  left_px [0:3] = '{default: 8'h00};
	logic [7:0]  upleft_px [0:3] = '{default: 8'h00};
	logic [2:0]  row_filt = psu_pkg::FILT_NONE;
	int          col_pos = 0;
	int          comp_pos = 0;
	logic        want_filter = 1'b1;
	logic        in_first_row = 1'b1;

	px_t         pending_samples [$];
	px_t         want_px;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	logic        gappy = 1'b0;
	int          rx_phase = 0;
	rx_mode_e    rx_mode = RX_ALWAYS;

	step_t directed_steps [0:DIRECTED_LEN-1] = '{
		'{STEP_BYTE,   13'h000, 3'd0, 1'b1, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h0ff, 3'd0, 1'b0, 1'b1, 8'hff, 2'd0, 1'b1},
		'{STEP_BYTE,   13'h002, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h001, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h0fd, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h080, 3'd0, 1'b0, 1'b1, 8'h80, 2'd0, 1'b1},
		'{STEP_CONFIG, 13'd2,   3'd2, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h001, 3'd0, 1'b1, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h0ff, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h001, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h0ff, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h002, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h003, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h010, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h020, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h0f0, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h0f0, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h004, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h07f, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h080, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h001, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h0ff, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h002, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h055, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		// start of image in the middle of a row
		'{STEP_BYTE,   13'h000, 3'd0, 1'b1, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h033, 3'd0, 1'b0, 1'b1, 8'h33, 2'd0, 1'b0},
		// zero registers act as one; shrinking mid-pixel ends the row at once
		'{STEP_CONFIG, 13'd0,   3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h044, 3'd0, 1'b0, 1'b1, 8'h44, 2'd0, 1'b1},
		'{STEP_BYTE,   13'h004, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0},
		'{STEP_BYTE,   13'h010, 3'd0, 1'b0, 1'b0, 8'h00, 2'd0, 1'b0}
	};

	png_scanline_unfilter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int width_of(input logic [12:0] w);
		if (w == 0)
			return 1;
		if (w > psu_pkg::DEF_MAX_WIDTH)
			return psu_pkg::DEF_MAX_WIDTH;
		return w;
	endfunction

	function automatic int depth_of(input logic [2:0] n);
		if (n == 0)
			return 1;
		if (n > psu_pkg::DEF_MAX_COMPONENTS)
			return psu_pkg::DEF_MAX_COMPONENTS;
		return n;
	endfunction

	function automatic int paeth_pick(input int a, input int b, input int c);
		int pa, pb, pc;
		pa = (b > c) ? b - c : c - b;
		pb = (a > c) ? a - c : c - a;
		pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
		if (pa <= pb && pa <= pc)
			return a;
		else if (pb <= pc)
			return b;
		return c;
	endfunction

	// mostly the five defined filters, now and then an unknown code
	function automatic logic [7:0] pick_filter();
		int r;
		r = $urandom_range(0, 19);
		if (r < 17)
			return 8'(r % 5);
		return 8'($urandom_range(5, 255));
	endfunction

	task automatic unfilter_byte(input logic [7:0] b, input logic sof,
			output logic produced, output px_t px);
		int w, bpp, col, comp, addr, left, up, ul, pred;
		logic [7:0] val;
		w = width_of(cfg_width);
		bpp = depth_of(cfg_bpp);
		produced = 1'b0;
		px = '0;
		if (sof) begin
			want_filter = 1'b1;
			in_first_row = 1'b1;
			col_pos = 0;
			comp_pos = 0;
		end
		if (want_filter) begin
			row_filt = (b <= psu_pkg::FILT_PAETH) ? b[2:0] : psu_pkg::FILT_NONE;
			for (int k = 0; k < 4; k++) begin
				left_px[k] = 8'h00;
				upleft_px[k] = 8'h00;
			end
			col_pos = 0;
			comp_pos = 0;
			want_filter = 1'b0;
		end else begin
			// positions beyond a reduced limit clamp to the last one
			col = (col_pos < w) ? col_pos : w - 1;
			comp = (comp_pos < bpp) ? comp_pos : bpp - 1;
			addr = col * psu_pkg::DEF_MAX_COMPONENTS + comp;
			left = left_px[comp];
			ul = upleft_px[comp];
			up = in_first_row ? 0 : prev_row[addr];
			case (row_filt)
				psu_pkg::FILT_SUB:   pred = left;
				psu_pkg::FILT_UP:    pred = up;
				psu_pkg::FILT_AVG:   pred = (left + up) >> 1;
				psu_pkg::FILT_PAETH: pred = paeth_pick(left, up, ul);
				default:             pred = 0;
			endcase
			val = 8'(b + pred);
			upleft_px[comp] = 8'(up);
			left_px[comp] = val;
			prev_row[addr] = val;
			px.sample = val;
			px.comp = comp[psu_pkg::COMP_W-1:0];
			px.last = (col + 1 >= w) && (comp + 1 >= bpp);
			produced = 1'b1;
			if (comp + 1 >= bpp) begin
				comp_pos = 0;
				if (col + 1 >= w) begin
					col_pos = 0;
					want_filter = 1'b1;
					in_first_row = 1'b0;
				end else begin
					col_pos = col + 1;
				end
			end else begin
				comp_pos = comp + 1;
				col_pos = col;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch in %s: got 0x%0h, want 0x%0h (cycle %0d)",
			what, got, want, cycle_count);
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic sof, input logic typed,
			input px_t typed_px);
		px_t px;
		logic produced;
		if (gappy && burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= sof;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		unfilter_byte(b, sof, produced, px);
		if (produced) begin
			if (typed)
				px = typed_px;
			pending_samples = {pending_samples, px};
		end
		if (burst_left > 0)
			burst_left--;
	endtask

	// hold off until every sample is out and the pipeline has drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [12:0] w, input logic [2:0] bpp);
		cfg_we <= 1'b1;
		cfg_index <= psu_pkg::REG_ROW_WIDTH;
		cfg_data <= psu_pkg::CFG_DATA_W'(w);
		@(posedge clk);
		cfg_width = w;
		cfg_index <= psu_pkg::REG_BYTES_PER_PIXEL;
		cfg_data <= psu_pkg::CFG_DATA_W'(bpp);
		@(posedge clk);
		cfg_bpp = bpp;
		cfg_we <= 1'b0;
	endtask

	// rows follow the predictor's position: filter codes where a row opens
	task automatic send_rows(input int n, input logic first_sof, input logic noisy);
		logic sof;
		logic [7:0] b;
		for (int k = 0; k < n; k++) begin
			sof = (k == 0 && first_sof)
				|| (noisy && $urandom_range(0, 199) == 0)
				|| (want_filter && $urandom_range(0, 23) == 0);
			if (sof || want_filter)
				b = pick_filter();
			else
				b = 8'($urandom);
			feed_byte(b, sof, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (rx_phase % 256 == 255)
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RX_ALWAYS:   m_axis_tready <= 1'b1;
			RX_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: m_axis_tready <= (rx_phase % 5 < 2);
			default:     m_axis_tready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_samples.size() == 0) begin
				report_mismatch("unexpected sample", m_axis_tdata, 0);
			end else begin
				want_px = pending_samples.pop_front();
				if (m_axis_tdata !== want_px.sample)
					report_mismatch("sample", m_axis_tdata, want_px.sample);
				if (m_axis_tuser !== want_px.comp)
					report_mismatch("component", m_axis_tuser, want_px.comp);
				if (m_axis_tlast !== want_px.last)
					report_mismatch("row_last", m_axis_tlast, want_px.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		px_t typed_px;
		int random_items, cur_w, cur_bpp, row_len, n, r;
		logic [12:0] new_w;
		logic [2:0] new_bpp;
		logic need_sof;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_LEN; i++) begin
			if (directed_steps[i].kind == STEP_CONFIG) begin
				settle();
				set_config(directed_steps[i].val, directed_steps[i].bpp);
			end else begin
				typed_px.sample = directed_steps[i].sample;
				typed_px.comp = directed_steps[i].comp;
				typed_px.last = directed_steps[i].last;
				feed_byte(directed_steps[i].val[7:0], directed_steps[i].sof,
					directed_steps[i].typed, typed_px);
			end
		end

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			cur_w = width_of(cfg_width);
			cur_bpp = depth_of(cfg_bpp);
			if ($urandom_range(0, 3) == 0) begin
				// shrink only, so the image can go on mid-row
				new_w = 13'($urandom_range(0, cur_w));
				new_bpp = 3'($urandom_range(0, cur_bpp));
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0)
					new_w = 13'd0;
				else if (r == 1)
					new_w = 13'd1;
				else if (r < 8)
					new_w = 13'($urandom_range(2, 12));
				else
					new_w = 13'($urandom_range(13, 40));
				new_bpp = 3'($urandom_range(0, 7));
			end
			// a larger row would read line store entries never written
			need_sof = (width_of(new_w) > cur_w) || (depth_of(new_bpp) > cur_bpp);
			settle();
			set_config(new_w, new_bpp);
			gappy = ($urandom_range(0, 3) != 0);
			row_len = 1 + width_of(new_w) * depth_of(new_bpp);
			n = $urandom_range(1, 6) * row_len;
			if ($urandom_range(0, 2) == 0)
				n += $urandom_range(1, row_len);
			if (n > RANDOM_ITEMS - random_items)
				n = RANDOM_ITEMS - random_items;
			send_rows(n, need_sof, 1'b1);
			random_items += n;
		end

		// out-of-range values clamp to the maxima; the start of a widest row
		settle();
		set_config(13'h1fff, 3'd7);
		gappy = 1'b1;
		send_rows(WIDE_ITEMS, 1'b1, 1'b0);

		settle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== png_scanline_unfilter.f =====
rtl/psu_pkg.sv
rtl/psu_ctrl.sv
rtl/psu_line_store.sv
rtl/psu_recon.sv
rtl/png_scanline_unfilter.sv
tb/sv/testbench.sv
